// File: sv/vwd_pkg.sv
// Shared types and constants for the vertex weld/dedup block.
// Standalone package; every other file in sv/ refers to it by scoped names.
`timescale 1ns / 1ps

package vwd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int COORD_W     = 32;
  localparam int TOL_W       = 31;
  localparam int IDX_W       = 10;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // Word index of the tolerance register (byte address 0).
  localparam logic REG_TOL = 1'b0;

  typedef struct packed {
    logic                      mesh_start;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } vtx_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             is_new;
    logic             table_full;
  } vtx_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord_t;

endpackage

// File: sv/vwd_store.sv
// Unique-vertex store: one write port, one read port with registered data.
// Depends on vwd_pkg (coord_t).
`timescale 1ns / 1ps

module vwd_store #(
  parameter int DEPTH = vwd_pkg::TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  vwd_pkg::coord_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output vwd_pkg::coord_t rd_data
);

  vwd_pkg::coord_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/vwd_match.sv
// Shared compare unit: per-axis 33-bit absolute difference against tolerance.
// Depends on vwd_pkg (coord_t, widths).
`timescale 1ns / 1ps

module vwd_match (
  input  vwd_pkg::coord_t            probe,
  input  vwd_pkg::coord_t            entry,
  input  logic [vwd_pkg::TOL_W-1:0]  tol,
  output logic                       hit
);

  localparam int DW = vwd_pkg::COORD_W + 1;

  function automatic logic axis_close(input logic signed [vwd_pkg::COORD_W-1:0] a,
                                      input logic signed [vwd_pkg::COORD_W-1:0] b,
                                      input logic [vwd_pkg::TOL_W-1:0] t);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        mag;
    d   = DW'(a) - DW'(b);
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    return mag < DW'(t);
  endfunction

  assign hit = axis_close(probe.x, entry.x, tol) &&
               axis_close(probe.y, entry.y, tol) &&
               axis_close(probe.z, entry.z, tol);

endmodule

// File: sv/vwd_ctrl.sv
// Scan sequencer: entry count, read issue, append/full decision, result register.
// Depends on vwd_pkg (vtx_in_t, vtx_out_t, coord_t).
`timescale 1ns / 1ps

module vwd_ctrl #(
  parameter int DEPTH = vwd_pkg::TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vtx_valid,
  output logic              vtx_ready,
  input  vwd_pkg::vtx_in_t  vtx,
  output logic              res_valid,
  input  logic              res_ready,
  output vwd_pkg::vtx_out_t res,
  output vwd_pkg::coord_t   probe,
  input  logic              hit,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr
);

  localparam int XW = vwd_pkg::IDX_W + AW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     issue;
  logic              dval;
  logic [AW-1:0]     didx;
  vwd_pkg::vtx_out_t res_hold;
  logic [XW-1:0]     hit_ext;
  logic [XW-1:0]     new_ext;
  logic              found;
  logic              exhausted;
  logic              is_full;
  logic              accept;
  logic              load_out;

  assign vtx_ready = (state == ST_IDLE);
  assign accept    = vtx_valid && vtx_ready;
  assign found     = (state == ST_SCAN) && dval && hit;
  assign exhausted = (state == ST_SCAN) && !dval && (issue == cnt);
  assign is_full   = (cnt == CW'(DEPTH));
  assign rd_en     = (state == ST_SCAN) && (issue < cnt) && !found;
  assign rd_addr   = issue[AW-1:0];
  assign wr_en     = exhausted && !is_full;
  assign wr_addr   = cnt[AW-1:0];
  assign hit_ext   = XW'(didx);
  assign new_ext   = XW'(cnt);
  assign load_out  = (state == ST_FIN) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      issue     <= '0;
      dval      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      dval <= rd_en;
      if (rd_en) begin
        issue <= issue + CW'(1);
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            issue <= '0;
            if (vtx.mesh_start) begin
              cnt <= '0;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (found || exhausted) begin
            state <= ST_FIN;
          end
          if (wr_en) begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload: probe vertex, pending result, result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      probe.x <= vtx.pos_x;
      probe.y <= vtx.pos_y;
      probe.z <= vtx.pos_z;
    end
    if (state == ST_SCAN) begin
      didx <= issue[AW-1:0];
    end
    if (found) begin
      res_hold.vertex_index <= hit_ext[vwd_pkg::IDX_W-1:0];
      res_hold.is_new       <= 1'b0;
      res_hold.table_full   <= 1'b0;
    end else if (exhausted) begin
      res_hold.vertex_index <= is_full ? '0 : new_ext[vwd_pkg::IDX_W-1:0];
      res_hold.is_new       <= !is_full;
      res_hold.table_full   <= is_full;
    end
    if (load_out) begin
      res <= res_hold;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cnt < CW'(DEPTH)))
    else $error("append into a full table");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.table_full) |-> (!res.is_new && res.vertex_index == '0))
    else $error("full result carries index or new flag");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !vtx_ready)
    else $error("ready while a vertex is in flight");

endmodule

// File: sv/vertex_weld_dedup_top.sv
// Top level of the vertex weld/dedup block: APB register, sequencer, store, compare.
// Depends on vwd_pkg, vwd_store, vwd_match, vwd_ctrl.
`timescale 1ns / 1ps

// Sequence: after acceptance, stored entries are read in index order and compared up to and
//   including the first match (all if none); the result register is then loaded when free.
// Throughput: one vertex at a time, bounded by the single store read port feeding one
//   compare per cycle.
// Reset (rst, synchronous, active high) empties the store count, clears the tolerance
//   to zero and drops any pending result; store contents are not cleared.
module vertex_weld_dedup_top #(
  parameter int TABLE_DEPTH = vwd_pkg::TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // Vertex input channel
  input  logic                        vtx_valid,
  output logic                        vtx_ready,
  input  vwd_pkg::vtx_in_t            vtx,
  // Result channel
  output logic                        res_valid,
  input  logic                        res_ready,
  output vwd_pkg::vtx_out_t           res,
  // Register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vwd_pkg::APB_AW-1:0]  paddr,
  input  logic [vwd_pkg::APB_DW-1:0]  pwdata,
  output logic [vwd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [vwd_pkg::TOL_W-1:0] weld_tolerance;
  logic                      reg_sel;
  logic                      cfg_wr;
  vwd_pkg::coord_t           probe;
  vwd_pkg::coord_t           entry;
  logic                      hit;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;

  // Register decode: one 32-bit word per register, selected by the word address bit.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write tolerance in the access phase; keep the low 31 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      weld_tolerance <= '0;
    end else if (cfg_wr && reg_sel == vwd_pkg::REG_TOL) begin
      weld_tolerance <= pwdata[vwd_pkg::TOL_W-1:0];
    end
  end

  // Read back the tolerance; unmapped words read as zero.
  always_comb begin
    unique case (reg_sel)
      vwd_pkg::REG_TOL: prdata = vwd_pkg::APB_DW'(weld_tolerance);
      default:          prdata = '0;
    endcase
  end

  // Sequencer: takes a vertex, walks stored entries in index order, appends or flags full.
  vwd_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .probe     (probe),
    .hit       (hit),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr)
  );

  // Store of unique vertices; the appended vertex is the probe held by the sequencer.
  vwd_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (probe),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (entry)
  );

  // One compare per cycle against the registered store output.
  vwd_match u_match (
    .probe (probe),
    .entry (entry),
    .tol   (weld_tolerance),
    .hit   (hit)
  );

endmodule
